// ----- sv/tsd_pkg.sv -----
// Shared types, constants and register codes of the tiered sample decimator.
package tsd_pkg;

  // Width of the record counter and of the tier quota.
  localparam int unsigned CountBits = 16;
  localparam int unsigned WordW     = 32;
  localparam int unsigned IdxW      = 16;
  localparam int unsigned CfgW      = 16;

  // Register reset values and limits.
  localparam logic [CfgW-1:0]  BaseIntervalRst = 16'd2000;
  localparam logic [CfgW-1:0]  MaxRecordsRst   = 16'd8000;
  localparam logic [WordW-1:0] IntervalMax     = 32'hFFFF_FFFF;

  // Function code of an input item.
  typedef enum logic {
    FUNC_SAMPLE = 1'b0,
    FUNC_START  = 1'b1
  } func_e;

  // Configuration register indexes.
  typedef enum logic {
    REG_BASE_INTERVAL = 1'b0,
    REG_MAX_RECORDS   = 1'b1
  } reg_idx_e;

  // One input item.
  typedef struct packed {
    func_e             func;
    logic [WordW-1:0]  time_ms;
    logic [WordW-1:0]  volt_word;
    logic [WordW-1:0]  current_word;
    logic [WordW-1:0]  temp_word;
    logic [WordW-1:0]  aux_a_word;
    logic [WordW-1:0]  aux_b_word;
  } sample_t;

  // One result item.
  typedef struct packed {
    logic              kept;
    logic [IdxW-1:0]   record_index;
    logic [WordW-1:0]  interval_now;
    logic [WordW-1:0]  rec_time;
    logic [WordW-1:0]  rec_volt;
    logic [WordW-1:0]  rec_current;
    logic [WordW-1:0]  rec_temp;
    logic [WordW-1:0]  rec_aux_a;
    logic [WordW-1:0]  rec_aux_b;
  } result_t;

endpackage

// ----- sv/tsd_in_reg.sv -----
// Input register stage: captures one accepted input transaction.
module tsd_in_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  tsd_pkg::sample_t item_i,
  output logic             valid_o,
  output tsd_pkg::sample_t item_o,
  input  logic             advance_i
);

  logic             valid_q, valid_d;
  tsd_pkg::sample_t item_q;

  // The stage takes a new item when empty or when its item moves on.
  assign ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- sv/tsd_core.sv -----
// Run state, configuration registers and the keep decision for one item.
module tsd_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [tsd_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                         fire_i,
  input  tsd_pkg::sample_t             item_i,
  output tsd_pkg::result_t             result_o
);

  localparam int unsigned Cb = tsd_pkg::CountBits;
  localparam int unsigned Ww = tsd_pkg::WordW;

  logic [tsd_pkg::CfgW-1:0] base_q, max_q;
  logic                     run_q, run_d;
  logic [Cb-1:0]            records_q, records_d;
  logic [Cb-1:0]            quota_q, quota_d;
  logic [Ww-1:0]            interval_q, interval_d;
  logic [Ww-1:0]            due_q, due_d;

  logic [Ww-1:0]            max_ext, rec_ext, remaining, doubled;
  logic [Cb-1:0]            half_quota, open_quota, quota_t;
  logic [Ww-1:0]            interval_t;
  logic                     due_hold, eligible, keep;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= tsd_pkg::BaseIntervalRst;
      max_q  <= tsd_pkg::MaxRecordsRst;
    end else if (cfg_we_i) begin
      unique case (tsd_pkg::reg_idx_e'(cfg_idx_i))
        tsd_pkg::REG_BASE_INTERVAL: base_q <= cfg_data_i;
        tsd_pkg::REG_MAX_RECORDS:   max_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Budget and tier arithmetic shared by the sample path.
  assign max_ext    = Ww'(max_q);
  assign rec_ext    = Ww'(records_q);
  assign remaining  = (max_ext > rec_ext) ? (max_ext - rec_ext) : '0;
  assign half_quota = Cb'(remaining >> 1);
  assign open_quota = (half_quota != '0) ? half_quota : Cb'(remaining);
  assign doubled    = interval_q[Ww-1] ? tsd_pkg::IntervalMax : {interval_q[Ww-2:0], 1'b0};
  assign due_hold   = (records_q != '0) && (item_i.time_ms < due_q);
  assign eligible   = run_q && !due_hold && (rec_ext < max_ext);

  // A spent quota opens a new tier before the sample is judged.
  assign quota_t    = (quota_q == '0) ? open_quota : quota_q;
  assign interval_t = (quota_q == '0) ? doubled : interval_q;

  always_comb begin
    run_d      = run_q;
    records_d  = records_q;
    quota_d    = quota_q;
    interval_d = interval_q;
    due_d      = due_q;
    keep       = 1'b0;
    unique case (item_i.func)
      tsd_pkg::FUNC_START: begin
        run_d      = 1'b1;
        records_d  = '0;
        quota_d    = Cb'(max_q >> 1);
        interval_d = Ww'(base_q);
        due_d      = '0;
      end
      tsd_pkg::FUNC_SAMPLE: begin
        if (eligible) begin
          quota_d    = quota_t;
          interval_d = interval_t;
          if (quota_t != '0) begin
            keep      = 1'b1;
            records_d = records_q + Cb'(1);
            quota_d   = quota_t - Cb'(1);
            due_d     = item_i.time_ms + interval_t;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q      <= 1'b0;
      records_q  <= '0;
      quota_q    <= '0;
      interval_q <= '0;
      due_q      <= '0;
    end else if (fire_i) begin
      run_q      <= run_d;
      records_q  <= records_d;
      quota_q    <= quota_d;
      interval_q <= interval_d;
      due_q      <= due_d;
    end
  end

  // Record fields are zero unless the sample is kept; the kept flag and the current interval are always set.
  always_comb begin
    result_o              = '0;
    result_o.kept         = keep;
    result_o.interval_now = interval_d;
    if (keep) begin
      result_o.record_index = tsd_pkg::IdxW'(Ww'(records_q));
      result_o.rec_time     = item_i.time_ms;
      result_o.rec_volt     = item_i.volt_word;
      result_o.rec_current  = item_i.current_word;
      result_o.rec_temp     = item_i.temp_word;
      result_o.rec_aux_a    = item_i.aux_a_word;
      result_o.rec_aux_b    = item_i.aux_b_word;
    end
  end

endmodule

// ----- sv/tsd_out_reg.sv -----
// Result register stage: holds one result transaction until the receiver takes it.
module tsd_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_valid_i,
  output logic             advance_o,
  input  tsd_pkg::result_t result_i,
  output logic             valid_o,
  input  logic             ready_i,
  output tsd_pkg::result_t result_o
);

  logic             valid_q, valid_d;
  tsd_pkg::result_t result_q;

  // The register can take a new result when empty or being drained.
  assign advance_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (advance_o) begin
      valid_d = load_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && load_valid_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ----- sv/tiered_sample_decimator.sv -----
// Tiered sample decimator: input register, keep decision and result register.
//
// Usage: configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i
// (index 0 base interval in ms, index 1 record budget) while the block is idle.
// Each input transaction on in_valid_i / in_ready_o carries func_i (start of a
// run or one sample), a timestamp and five raw reading words. Every input
// transaction gives exactly one result transaction on out_valid_o /
// out_ready_i, in order: kept flag, record index, current interval and the
// kept sample's words (zero when not kept).
// An accepted input waits in the input register; out_valid_o rises when the
// decision and state update load the result register, which waits while a
// stalled result is held. Throughput is one transaction per cycle while the
// receiver does not stall; the run state is updated as each item moves
// between the two registers, so consecutive samples see each other's effect.
// Reset clears both stages, the run state (no run open) and loads the
// register defaults of 2000 ms and 8000 records.
// When the receiver stalls, the result register holds its transaction, the
// input register still takes one more item, and in_ready_o then drops until
// the result is taken.
module tiered_sample_decimator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_idx_i,
  input  logic [tsd_pkg::CfgW-1:0]       cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           func_i,
  input  logic [tsd_pkg::WordW-1:0]      time_ms_i,
  input  logic [tsd_pkg::WordW-1:0]      volt_word_i,
  input  logic [tsd_pkg::WordW-1:0]      current_word_i,
  input  logic [tsd_pkg::WordW-1:0]      temp_word_i,
  input  logic [tsd_pkg::WordW-1:0]      aux_a_word_i,
  input  logic [tsd_pkg::WordW-1:0]      aux_b_word_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           kept_o,
  output logic [tsd_pkg::IdxW-1:0]       record_index_o,
  output logic [tsd_pkg::WordW-1:0]      interval_now_o,
  output logic [tsd_pkg::WordW-1:0]      rec_time_o,
  output logic [tsd_pkg::WordW-1:0]      rec_volt_o,
  output logic [tsd_pkg::WordW-1:0]      rec_current_o,
  output logic [tsd_pkg::WordW-1:0]      rec_temp_o,
  output logic [tsd_pkg::WordW-1:0]      rec_aux_a_o,
  output logic [tsd_pkg::WordW-1:0]      rec_aux_b_o
);

  tsd_pkg::sample_t in_item, held_item;
  tsd_pkg::result_t next_result, out_result;
  logic             held_valid, advance, fire;

  // Pack the input ports.
  always_comb begin
    in_item.func         = tsd_pkg::func_e'(func_i);
    in_item.time_ms      = time_ms_i;
    in_item.volt_word    = volt_word_i;
    in_item.current_word = current_word_i;
    in_item.temp_word    = temp_word_i;
    in_item.aux_a_word   = aux_a_word_i;
    in_item.aux_b_word   = aux_b_word_i;
  end

  tsd_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .ready_o   (in_ready_o),
    .item_i    (in_item),
    .valid_o   (held_valid),
    .item_o    (held_item),
    .advance_i (advance)
  );

  // State advances exactly when the held item moves into the result register.
  assign fire = held_valid && advance;

  tsd_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .fire_i     (fire),
    .item_i     (held_item),
    .result_o   (next_result)
  );

  tsd_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (held_valid),
    .advance_o    (advance),
    .result_i     (next_result),
    .valid_o      (out_valid_o),
    .ready_i      (out_ready_i),
    .result_o     (out_result)
  );

  // Unpack the result onto the output ports.
  assign kept_o         = out_result.kept;
  assign record_index_o = out_result.record_index;
  assign interval_now_o = out_result.interval_now;
  assign rec_time_o     = out_result.rec_time;
  assign rec_volt_o     = out_result.rec_volt;
  assign rec_current_o  = out_result.rec_current;
  assign rec_temp_o     = out_result.rec_temp;
  assign rec_aux_a_o    = out_result.rec_aux_a;
  assign rec_aux_b_o    = out_result.rec_aux_b;

endmodule

// ----- sv/tsd_checker.sv -----
// Port-level checker for the tiered sample decimator, bound to the top level.
module tsd_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic                      kept_o,
  input logic [tsd_pkg::IdxW-1:0]  record_index_o,
  input logic [tsd_pkg::WordW-1:0] interval_now_o,
  input logic [tsd_pkg::WordW-1:0] rec_time_o,
  input logic [tsd_pkg::WordW-1:0] rec_volt_o
);

  // A stalled result transaction stays valid and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kept_o) &&
      $stable(record_index_o) && $stable(interval_now_o) && $stable(rec_time_o))
    else $error("stalled result changed");

  // Input back-pressure only comes from a full result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled while result register empty");

  // A sample that is not kept reports no record.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !kept_o |-> record_index_o == '0 && rec_time_o == '0 &&
      rec_volt_o == '0)
    else $error("dropped sample carries record data");

endmodule

bind tiered_sample_decimator tsd_checker u_tsd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .kept_o         (kept_o),
  .record_index_o (record_index_o),
  .interval_now_o (interval_now_o),
  .rec_time_o     (rec_time_o),
  .rec_volt_o     (rec_volt_o)
);
